### rtl/core/rfb_pkg.sv
// ----------------------------------------------------------------------------
// RFB parser package
// Shared types, codes and constants of the remote framebuffer message parser.
// ----------------------------------------------------------------------------
package rfb_pkg;

   localparam int BytesPerPixel = 4;
   localparam int QueueDepth    = 4;

   localparam logic [7:0] MsgUpdate = 8'd0;
   localparam logic [7:0] MsgBell   = 8'd2;
   localparam logic [7:0] MsgCut    = 8'd3;
   localparam logic [7:0] MsgCont   = 8'd150;
   localparam logic [3:0] RectHdrLen = 4'd12;
   localparam logic [3:0] CutHdrLen  = 4'd8;
   localparam logic [31:0] ContSkip  = 32'd9;

   typedef enum logic [2:0] {
      KIND_PIXEL   = 3'd0,
      KIND_COPY    = 3'd1,
      KIND_BELL    = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_UNSUPP  = 3'd4,
      KIND_UNKNOWN = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_UPDATE = 3'd1,
      PH_RECT   = 3'd2,
      PH_PIXEL  = 3'd3,
      PH_COPY   = 3'd4,
      PH_CUTHDR = 3'd5,
      PH_SKIP   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CSR_FIRST_SHIFT  = 3'd0,
      CSR_SECOND_SHIFT = 3'd1,
      CSR_THIRD_SHIFT  = 3'd2,
      CSR_FIRST_MASK   = 3'd3,
      CSR_SECOND_MASK  = 3'd4,
      CSR_THIRD_MASK   = 3'd5
   } csr_index_type;

   // One classified command from the front parser to the back end.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] dest_x;
      logic [15:0] dest_y;
      logic [15:0] source_x;
      logic [15:0] source_y;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [23:0] pixel;
      logic        with_done;
   } cmd_type;

   // Packed result: kind, dest_x, dest_y, source_x, source_y, width,
   // height, first, second, third, from the lowest bit up.
   localparam int RspDataBits = 3 + 6 * 16 + 3 * 8;
   localparam int RspDataWidth = ((RspDataBits + 7) / 8) * 8;

endpackage

### rtl/core/remote_framebuffer_message_parser_core.sv
// ----------------------------------------------------------------------------
// Remote framebuffer message parser core
// Parses the server byte stream into pixel writes, copies and events.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | tvalid/tready       | tdata: data_byte
//  rsp     | out | tvalid/tready/tlast | tdata: kind..channel_third
//  csr     | in  | wen                 | index, data
//
// One byte is taken per cycle; the front parser decides in that cycle and
// pushes a command into a four-entry queue. The back end drains one result
// per cycle while rsp_tready is high; a command that closes the frame
// is sent, then a done result. Reset is synchronous and clears parser
// state and the queue. The input stalls only when the queue is nearly full.
module remote_framebuffer_message_parser_core
   import rfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kind, dest_x, dest_y, source_x, source_y, rect_width, rect_height,
   // channel_first, channel_second, channel_third
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic        rsp_tlast,    // last_of_run
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [4:0]  sh1_ff, sh2_ff, sh3_ff;
   logic [15:0] mk1_ff, mk2_ff, mk3_ff;
   logic        cmd_valid, space_ok;
   cmd_type     cmd;

   // hold config registers; write on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         sh1_ff <= 5'd16; sh2_ff <= 5'd8; sh3_ff <= 5'd0;
         mk1_ff <= 16'd255; mk2_ff <= 16'd255; mk3_ff <= 16'd255;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_FIRST_SHIFT:  sh1_ff <= csr_data[4:0];
            CSR_SECOND_SHIFT: sh2_ff <= csr_data[4:0];
            CSR_THIRD_SHIFT:  sh3_ff <= csr_data[4:0];
            CSR_FIRST_MASK:   mk1_ff <= csr_data;
            CSR_SECOND_MASK:  mk2_ff <= csr_data;
            CSR_THIRD_MASK:   mk3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = space_ok;

   rfb_front u_front (
      .clock, .reset,
      .byte_valid(req_tvalid && req_tready),
      .data_byte(req_tdata),
      .cmd_valid, .cmd
   );

   rfb_back #(.DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .space_ok,
      .sh1(sh1_ff), .sh2(sh2_ff), .sh3(sh3_ff),
      .mk1(mk1_ff), .mk2(mk2_ff), .mk3(mk3_ff),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule

### rtl/core/rfb_front.sv
// ----------------------------------------------------------------------------
// RFB front parser
// Takes one stream byte per cycle, tracks message framing, pushes commands.
// ----------------------------------------------------------------------------
module rfb_front
   import rfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    byte_valid,
   input  logic [7:0] data_byte,
   output logic    cmd_valid,
   output cmd_type cmd
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] rects_ff, rects_in;
   logic [15:0] hx_ff, hx_in, hy_ff, hy_in, hw_ff, hw_in, hh_ff, hh_in;
   logic [31:0] enc_ff, enc_in;
   logic [15:0] col_ff, col_in, row_ff, row_in;
   logic [23:0] acc_ff, acc_in;
   logic [15:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [31:0] skip_ff, skip_in;

   logic [15:0] rects_dec;
   logic [15:0] col_inc, row_inc;

   assign rects_dec = rects_ff - 16'd1;
   assign col_inc   = col_ff + 16'd1;
   assign row_inc   = row_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff; idx_in = idx_ff; rects_in = rects_ff;
      hx_in = hx_ff; hy_in = hy_ff; hw_in = hw_ff; hh_in = hh_ff; enc_in = enc_ff;
      col_in = col_ff; row_in = row_ff; acc_in = acc_ff;
      sx_in = sx_ff; sy_in = sy_ff; skip_in = skip_ff;
      cmd_valid = 1'b0;
      cmd = '0;
      if (byte_valid) begin
         case (phase_ff)
            PH_UPDATE: begin
               if (idx_ff >= 4'd2) rects_in = {rects_ff[7:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd3) begin
                  idx_in = '0;
                  phase_in = ({rects_ff[7:0], data_byte} == 16'd0) ? PH_IDLE : PH_RECT;
               end
            end
            PH_RECT: begin
               if (idx_ff < 4'd2) hx_in = {hx_ff[7:0], data_byte};
               else if (idx_ff < 4'd4) hy_in = {hy_ff[7:0], data_byte};
               else if (idx_ff < 4'd6) hw_in = {hw_ff[7:0], data_byte};
               else if (idx_ff < 4'd8) hh_in = {hh_ff[7:0], data_byte};
               else enc_in = {enc_ff[23:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_ff == RectHdrLen - 4'd1) begin
                  idx_in = '0;
                  col_in = '0;
                  row_in = '0;
                  if (enc_in == 32'd0) begin
                     if (hw_ff == 16'd0 || hh_ff == 16'd0) begin
                        rects_in = rects_dec;
                        if (rects_dec == 16'd0) begin
                           phase_in = PH_IDLE;
                           cmd_valid = 1'b1;
                           cmd.kind = KIND_DONE;
                        end
                     end else begin
                        phase_in = PH_PIXEL;
                     end
                  end else if (enc_in == 32'd1) begin
                     phase_in = PH_COPY;
                  end else begin
                     rects_in = rects_dec;
                     cmd_valid = 1'b1;
                     cmd.kind = KIND_UNSUPP;
                     cmd.with_done = (rects_dec == 16'd0);
                     if (rects_dec == 16'd0) phase_in = PH_IDLE;
                  end
               end
            end
            PH_PIXEL: begin
               if (idx_ff < 4'd3) acc_in = {acc_ff[15:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'(BytesPerPixel - 1)) begin
                  idx_in = '0;
                  cmd_valid = 1'b1;
                  cmd.kind = KIND_PIXEL;
                  cmd.dest_x = hx_ff + col_ff;
                  cmd.dest_y = hy_ff + row_ff;
                  cmd.pixel = acc_ff;
                  col_in = col_inc;
                  if (col_inc >= hw_ff) begin
                     col_in = '0;
                     row_in = row_inc;
                     if (row_inc >= hh_ff) begin
                        rects_in = rects_dec;
                        cmd.with_done = (rects_dec == 16'd0);
                        phase_in = (rects_dec == 16'd0) ? PH_IDLE : PH_RECT;
                     end
                  end
               end
            end
            PH_COPY: begin
               if (idx_ff < 4'd2) sx_in = {sx_ff[7:0], data_byte};
               else sy_in = {sy_ff[7:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd3) begin
                  idx_in = '0;
                  cmd_valid = 1'b1;
                  cmd.kind = KIND_COPY;
                  cmd.dest_x = hx_ff;
                  cmd.dest_y = hy_ff;
                  cmd.source_x = sx_ff;
                  cmd.source_y = sy_in;
                  cmd.rect_width = hw_ff;
                  cmd.rect_height = hh_ff;
                  rects_in = rects_dec;
                  cmd.with_done = (rects_dec == 16'd0);
                  phase_in = (rects_dec == 16'd0) ? PH_IDLE : PH_RECT;
               end
            end
            PH_CUTHDR: begin
               if (idx_ff >= 4'd4) skip_in = {skip_ff[23:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_ff == CutHdrLen - 4'd1) begin
                  idx_in = '0;
                  phase_in = (skip_in == 32'd0) ? PH_IDLE : PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_in == 32'd0) phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
               idx_in = '0;
               if (data_byte == MsgUpdate) begin
                  rects_in = '0;
                  idx_in = 4'd1;
                  phase_in = PH_UPDATE;
               end else if (data_byte == MsgBell) begin
                  cmd_valid = 1'b1;
                  cmd.kind = KIND_BELL;
               end else if (data_byte == MsgCut) begin
                  skip_in = '0;
                  idx_in = 4'd1;
                  phase_in = PH_CUTHDR;
               end else if (data_byte == MsgCont) begin
                  skip_in = ContSkip;
                  phase_in = PH_SKIP;
               end else begin
                  cmd_valid = 1'b1;
                  cmd.kind = KIND_UNKNOWN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; idx_ff <= '0; rects_ff <= '0;
         hx_ff <= '0; hy_ff <= '0; hw_ff <= '0; hh_ff <= '0; enc_ff <= '0;
         col_ff <= '0; row_ff <= '0; acc_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; skip_ff <= '0;
      end else begin
         phase_ff <= phase_in; idx_ff <= idx_in; rects_ff <= rects_in;
         hx_ff <= hx_in; hy_ff <= hy_in; hw_ff <= hw_in; hh_ff <= hh_in; enc_ff <= enc_in;
         col_ff <= col_in; row_ff <= row_in; acc_ff <= acc_in;
         sx_ff <= sx_in; sy_ff <= sy_in; skip_ff <= skip_in;
      end
   end

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < RectHdrLen) else $error("byte index out of range");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.with_done |=> phase_ff == PH_IDLE)
      else $error("frame done without return to idle");
   a_pixel_rects: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXEL |-> rects_ff != 16'd0) else $error("pixel with no rects");
`endif

endmodule

### rtl/core/rfb_back.sv
// ----------------------------------------------------------------------------
// RFB back end
// Queues commands, splits a frame-done tail, forms colour bytes.
// ----------------------------------------------------------------------------
module rfb_back
   import rfb_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        space_ok,
   input  logic [4:0]  sh1, sh2, sh3,
   input  logic [15:0] mk1, mk2, mk3,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type q_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          tail_ff, tail_in;   // command part of head already sent, done part pending
   logic          push, pop;
   cmd_type       head;
   logic [23:0]   c1, c2, c3;

   assign head = q_ff[rp_ff];
   assign push = cmd_valid;
   // keep room for one more command beyond the in-flight byte
   assign space_ok = cnt_ff <= (AW+1)'(DEPTH - 2);
   assign rsp_tvalid = cnt_ff != '0;
   assign pop = rsp_tvalid && rsp_tready &&
                (!head.with_done || tail_ff || head.kind == KIND_DONE);

   assign c1 = (head.pixel >> sh1) & {8'd0, mk1};
   assign c2 = (head.pixel >> sh2) & {8'd0, mk2};
   assign c3 = (head.pixel >> sh3) & {8'd0, mk3};

   always_comb begin
      rsp_tdata = '0;
      rsp_tlast = 1'b1;
      if (head.with_done && tail_ff) begin
         rsp_tdata[2:0] = KIND_DONE;
      end else begin
         rsp_tlast = !head.with_done;
         rsp_tdata[2:0]     = head.kind;
         rsp_tdata[18:3]    = head.dest_x;
         rsp_tdata[34:19]   = head.dest_y;
         rsp_tdata[50:35]   = head.source_x;
         rsp_tdata[66:51]   = head.source_y;
         rsp_tdata[82:67]   = head.rect_width;
         rsp_tdata[98:83]   = head.rect_height;
         if (head.kind == KIND_PIXEL) begin
            rsp_tdata[106:99]  = c1[7:0];
            rsp_tdata[114:107] = c2[7:0];
            rsp_tdata[122:115] = c3[7:0];
         end
      end
   end

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      if (pop)  rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      tail_in = tail_ff;
      if (pop) tail_in = 1'b0;
      else if (rsp_tvalid && rsp_tready && head.with_done) tail_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; tail_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in; tail_ff <= tail_in;
      end
   end

`ifndef SYNTHESIS
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff < (AW+1)'(DEPTH)) else $error("queue overflow");
   a_tail: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> rsp_tvalid && head.with_done) else $error("stray tail");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("count out of range");
`endif

endmodule
